/* rtl/core/dcc_half_bit_decoder_top_macros.svh */
// Assertion macros for the DCC half-bit decoder.
// Used by dcc_half_bit_decoder_top.sv; expects clk and rst_n in scope.
`ifndef DCC_HALF_BIT_DECODER_TOP_MACROS_SVH
`define DCC_HALF_BIT_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define DHB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define DHB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dcc_hb_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the DCC half-bit decoder: field widths,
// configuration register indexes and register reset values. No dependencies.
package dcc_hb_pkg;

    localparam int TIME_W = 16;
    localparam int CFG_IDX_W = 3;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Configuration register indexes.
    localparam cfg_idx_t REG_ONE_MIN        = 3'd0;
    localparam cfg_idx_t REG_ONE_MAX        = 3'd1;
    localparam cfg_idx_t REG_ZERO_MIN       = 3'd2;
    localparam cfg_idx_t REG_ZERO_MAX       = 3'd3;
    localparam cfg_idx_t REG_HALF_TOLERANCE = 3'd4;

    // Register reset values, in microseconds.
    localparam time_t ONE_MIN_RST        = 16'd52;
    localparam time_t ONE_MAX_RST        = 16'd64;
    localparam time_t ZERO_MIN_RST       = 16'd90;
    localparam time_t ZERO_MAX_RST       = 16'd10000;
    localparam time_t HALF_TOLERANCE_RST = 16'd6;

    // Half-period slots start out at the largest interval.
    localparam time_t HALF_RST = 16'hFFFF;

endpackage

/* rtl/core/dcc_half_bit_decoder_top.sv */
`timescale 1ns / 1ps
// Top level of the DCC half-bit decoder: edge timestamps in, decoded bits out.
// Depends on dcc_hb_pkg and dcc_half_bit_decoder_top_macros.svh.
//
// The decoder takes one edge timestamp beat per clock cycle unless stalled and
// returns a decoded bit in a result register: the beat lands in an input register,
// then one pass of subtract-and-compare logic updates the half-period
// slots and loads the result register. Throughput is one
// timestamp per cycle as long as the result register is drained; a result
// held by a stalled consumer stops the input stage until it is taken.
// An edge that closes a pair (relative to the phase mark) may yield
// one bit: 1 for a pair whose first half is short and whose halves match within the tolerance,
// 0 for a pair of long halves. A mixed pair that does not make a 1 yields nothing and
// shifts the pairing by one edge. Configuration writes take effect at once
// and are meant to be made while no timestamp is in flight.
`include "dcc_half_bit_decoder_top_macros.svh"

module dcc_half_bit_decoder_top
    import dcc_hb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Edge timestamp channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [TIME_W-1:0]    edge_time,
    // Decoded bit channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 bit_value,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_wdata
);

    // Configuration registers
    time_t one_min_reg, one_max_reg, zero_min_reg, zero_max_reg, half_tol_reg;

    // Decoder state
    time_t last_edge_reg;
    time_t half0_reg;
    time_t half1_reg;
    logic  slot_reg;
    logic  phase_reg;

    // Input stage and result stage
    logic  s1_valid_reg;
    time_t s1_time_reg;
    logic  out_valid_reg;
    logic  out_bit_reg;

    // Combinational pass
    time_t interval;
    time_t half0_next;
    time_t half1_next;
    logic  slot_next;
    logic  pair_done;
    logic  a_one, a_zero, b_one, b_zero;
    time_t half_diff;
    logic  tol_ok;
    logic  emit_one, emit_zero, phase_flip;
    logic  s1_fire;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_min_reg  <= ONE_MIN_RST;
            one_max_reg  <= ONE_MAX_RST;
            zero_min_reg <= ZERO_MIN_RST;
            zero_max_reg <= ZERO_MAX_RST;
            half_tol_reg <= HALF_TOLERANCE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ONE_MIN:        one_min_reg  <= cfg_wdata;
                REG_ONE_MAX:        one_max_reg  <= cfg_wdata;
                REG_ZERO_MIN:       zero_min_reg <= cfg_wdata;
                REG_ZERO_MAX:       zero_max_reg <= cfg_wdata;
                REG_HALF_TOLERANCE: half_tol_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // The input stage moves on when the result register is free or drains now.
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    // Interval since the previous edge, wrapping with the timer.
    assign interval   = s1_time_reg - last_edge_reg;
    assign half0_next = (slot_reg == 1'b0) ? interval : half0_reg;
    assign half1_next = (slot_reg == 1'b1) ? interval : half1_reg;
    assign slot_next  = ~slot_reg;
    assign pair_done  = (phase_reg == slot_next);

    // Window tests on both halves of the pair.
    assign a_one  = (half0_next >= one_min_reg)  && (half0_next <= one_max_reg);
    assign a_zero = (half0_next >= zero_min_reg) && (half0_next <= zero_max_reg);
    assign b_one  = (half1_next >= one_min_reg)  && (half1_next <= one_max_reg);
    assign b_zero = (half1_next >= zero_min_reg) && (half1_next <= zero_max_reg);

    // True absolute difference of the two halves.
    assign half_diff = (half0_next >= half1_next) ? (half0_next - half1_next)
                                                  : (half1_next - half0_next);
    assign tol_ok    = (half_diff <= half_tol_reg);

    // Classification: the one window is tested first.
    assign emit_one   = pair_done && a_one && tol_ok;
    assign emit_zero  = pair_done && !a_one && a_zero && b_zero;
    assign phase_flip = pair_done &&
                        ((a_one && !tol_ok && b_zero) ||
                         (!a_one && a_zero && !b_zero && b_one));

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_time_reg <= edge_time;
        end
    end

    // Decoder state update, one edge per pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg <= '0;
            half0_reg     <= HALF_RST;
            half1_reg     <= HALF_RST;
            slot_reg      <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else if (s1_fire)
        begin
            last_edge_reg <= s1_time_reg;
            half0_reg     <= half0_next;
            half1_reg     <= half1_next;
            slot_reg      <= slot_next;
            phase_reg     <= phase_reg ^ phase_flip;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= emit_one || emit_zero;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_bit_reg <= emit_one;
        end
    end

    assign out_valid = out_valid_reg;
    assign bit_value = out_bit_reg;

    // A result is produced only when the pair closes at the phase mark.
    `DHB_ASSERT_NOW(a_emit_on_pair, s1_fire && (emit_one || emit_zero), pair_done, "result emitted off the pair boundary")
    // The phase mark moves only while an edge is processed.
    `DHB_ASSERT_NEXT(a_phase_hold, !s1_fire, $stable(phase_reg), "phase mark changed without an edge")
    // A one and a zero never come from the same pair, and never with a flip.
    `DHB_ASSERT_NOW(a_class_excl, s1_fire, !(emit_one && emit_zero) && !((emit_one || emit_zero) && phase_flip), "pair classified more than one way")
    // The slot pointer toggles on every processed edge.
    `DHB_ASSERT_NEXT(a_slot_toggle, s1_fire, slot_reg != $past(slot_reg), "slot pointer did not toggle")

endmodule

/* tb/tb_dcc_half_bit_decoder_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for dcc_half_bit_decoder_top: drives edge timestamps and
// configuration writes, predicts decoded bits and checks every output beat.
// Depends on dcc_hb_pkg and the decoder RTL.

// Tracks the pairing state of the decoder and holds the bits it must produce.
class dcc_pair_scoreboard;
    dcc_hb_pkg::time_t one_min;
    dcc_hb_pkg::time_t one_max;
    dcc_hb_pkg::time_t zero_min;
    dcc_hb_pkg::time_t zero_max;
    dcc_hb_pkg::time_t half_tolerance;
    dcc_hb_pkg::time_t last_edge;
    dcc_hb_pkg::time_t half_times [2];
    bit                slot;
    bit                phase_mark;
    bit                pending_bits [$];
    int                errors;

    function new();
        one_min        = dcc_hb_pkg::ONE_MIN_RST;
        one_max        = dcc_hb_pkg::ONE_MAX_RST;
        zero_min       = dcc_hb_pkg::ZERO_MIN_RST;
        zero_max       = dcc_hb_pkg::ZERO_MAX_RST;
        half_tolerance = dcc_hb_pkg::HALF_TOLERANCE_RST;
        last_edge      = '0;
        half_times[0]  = dcc_hb_pkg::HALF_RST;
        half_times[1]  = dcc_hb_pkg::HALF_RST;
        slot           = 1'b0;
        phase_mark     = 1'b0;
        errors         = 0;
    endfunction

    // Indexes past the last register are dropped by the block.
    function void set_reg(dcc_hb_pkg::cfg_idx_t idx, dcc_hb_pkg::time_t v);
        case (idx)
            dcc_hb_pkg::REG_ONE_MIN:        one_min = v;
            dcc_hb_pkg::REG_ONE_MAX:        one_max = v;
            dcc_hb_pkg::REG_ZERO_MIN:       zero_min = v;
            dcc_hb_pkg::REG_ZERO_MAX:       zero_max = v;
            dcc_hb_pkg::REG_HALF_TOLERANCE: half_tolerance = v;
            default: ;
        endcase
    endfunction

    function bit in_one(dcc_hb_pkg::time_t t);
        return (t >= one_min) && (t <= one_max);
    endfunction

    function bit in_zero(dcc_hb_pkg::time_t t);
        return (t >= zero_min) && (t <= zero_max);
    endfunction

    // Store the interval of an accepted edge and classify the pair when it closes.
    function void take_edge(dcc_hb_pkg::time_t now);
        dcc_hb_pkg::time_t first_half;
        dcc_hb_pkg::time_t second_half;
        dcc_hb_pkg::time_t gap_diff;
        half_times[slot] = now - last_edge;
        last_edge = now;
        slot = ~slot;
        if (phase_mark != slot)
            return;
        first_half  = half_times[0];
        second_half = half_times[1];
        if (in_one(first_half))
        begin
            gap_diff = (first_half >= second_half) ? first_half - second_half
                                                   : second_half - first_half;
            if (gap_diff <= half_tolerance)
            begin
                pending_bits.push_back(1'b1);
                return;
            end
            // A short half followed by a long one means the pairing is off by one edge.
            if (in_zero(second_half))
                phase_mark = ~phase_mark;
        end
        else if (in_zero(first_half))
        begin
            if (in_zero(second_half))
            begin
                pending_bits.push_back(1'b0);
                return;
            end
            if (in_one(second_half))
                phase_mark = ~phase_mark;
        end
    endfunction

    function void check_bit(logic actual);
        bit want;
        if (pending_bits.size() == 0)
        begin
            $error("bit_value: expected no beat, actual %0b", actual);
            errors++;
            return;
        end
        want = pending_bits.pop_front();
        if (actual !== want)
        begin
            $error("bit_value mismatch: expected %0b, actual %0b", want, actual);
            errors++;
        end
    endfunction
endclass

module tb_dcc_half_bit_decoder_top;
    import dcc_hb_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 225;
    localparam int NUM_PHASES    = 7;
    localparam int TIMEOUT_NS    = 2000000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [TIME_W-1:0]    edge_time;
    logic                 out_valid;
    logic                 out_ready;
    logic                 bit_value;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TIME_W-1:0]    cfg_wdata;

    dcc_pair_scoreboard sb;
    time_t              last_sent;
    time_t              prev_gap;
    int                 send_idle_pct;
    int                 recv_idle_pct;

    dcc_half_bit_decoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .edge_time (edge_time),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .bit_value (bit_value),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Consumer side: random back-pressure on the decoded bit channel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Observe both channels; an output beat never depends on an input of the same edge.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_bit(bit_value);
        if (in_valid && in_ready)
            sb.take_edge(edge_time);
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[dcc_half_bit_decoder_top] ERROR");
        $finish;
    end

    function automatic time_t clip16(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return 16'hFFFF;
        return time_t'(v);
    endfunction

    // Choose the next interval: mostly near the current windows, some matched
    // halves, and some noise over the whole range.
    function automatic time_t pick_gap();
        int r;
        int lo;
        int hi;
        int span;
        r = $urandom_range(99);
        if (r < 15)
            return time_t'($urandom);
        if (r < 30)
        begin
            span = int'(sb.half_tolerance) + 2;
            return clip16(int'(prev_gap) + int'($urandom_range(2 * span)) - span);
        end
        if (r < 65)
        begin
            lo = int'(sb.one_min);
            hi = int'(sb.one_max);
        end
        else
        begin
            lo = int'(sb.zero_min);
            hi = int'(sb.zero_max);
        end
        if (lo > hi)
        begin
            r  = lo;
            lo = hi;
            hi = r;
        end
        // Hit the window edges often, including up to three steps outside.
        if ($urandom_range(3) == 0)
        begin
            if ($urandom_range(1) == 1)
                return clip16(lo - 3 + int'($urandom_range(6)));
            return clip16(hi - 3 + int'($urandom_range(6)));
        end
        return time_t'($urandom_range(hi, lo));
    endfunction

    task automatic send_edge(input time_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        edge_time <= t;
        last_sent  = t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_gap(input time_t gap);
        prev_gap = gap;
        send_edge(last_sent + gap);
    endtask

    // Hold off the sender until every pending bit has come out and the pipe is empty.
    task automatic drain_bits();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_bits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input cfg_idx_t idx, input time_t v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic program_windows(input time_t o_min, input time_t o_max,
                                   input time_t z_min, input time_t z_max,
                                   input time_t tol);
        write_reg(REG_ONE_MIN, o_min);
        write_reg(REG_ONE_MAX, o_max);
        write_reg(REG_ZERO_MIN, z_min);
        write_reg(REG_ZERO_MAX, z_max);
        write_reg(REG_HALF_TOLERANCE, tol);
        // A write past the last register must change nothing.
        write_reg(cfg_idx_t'(REG_HALF_TOLERANCE + 1 + $urandom_range(2)), time_t'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Directed intervals at the default windows: tolerance limits, window edges,
    // unclassified pairs, mixed pairs that shift the pairing, zero-length gaps.
    time_t directed_gaps [21] = '{
        16'd52, 16'd58, 16'd64, 16'd57, 16'd51, 16'd51, 16'd65, 16'd65,
        16'd90, 16'd10000, 16'd10001, 16'd90, 16'd58, 16'd100, 16'd100,
        16'd58, 16'd58, 16'd0, 16'd0, 16'hFFFF, 16'd60
    };

    initial
    begin
        time_t win_lo;
        time_t zero_lo;

        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        edge_time <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        last_sent = '0;
        prev_gap  = '0;
        send_idle_pct = 9;
        recv_idle_pct = 74;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme timestamps first; the second one wraps the timer.
        send_edge(16'hFFFF);
        send_edge(16'h0000);
        foreach (directed_gaps[i])
            send_gap(directed_gaps[i]);
        drain_bits();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 74;
            end
            else if (p < 4)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (p)
                1:
                begin
                    win_lo  = time_t'($urandom_range(60, 40));
                    zero_lo = time_t'($urandom_range(120, 80));
                    program_windows(win_lo, win_lo + time_t'($urandom_range(20)), zero_lo,
                                    time_t'($urandom_range(12000, 200)),
                                    time_t'($urandom_range(10)));
                end
                // Both windows cover everything; the one test wins.
                2: program_windows(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
                3: program_windows(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                // Empty one window.
                4: program_windows(16'hFFFF, 16'd1, 16'd1, 16'hFFFF,
                                   time_t'($urandom_range(30)));
                // Empty zero window.
                5: program_windows(16'd50, 16'd70, 16'hFFFF, 16'd0, 16'd20);
                6: program_windows(ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
                                   HALF_TOLERANCE_RST);
                default: ;
            endcase

            repeat (PHASE_ITEMS) send_gap(pick_gap());
            drain_bits();
        end

        if (sb.errors == 0 && sb.pending_bits.size() == 0)
            $display("[dcc_half_bit_decoder_top] OK");
        else
            $display("[dcc_half_bit_decoder_top] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/dcc_hb_pkg.sv
rtl/core/dcc_half_bit_decoder_top.sv
tb/tb_dcc_half_bit_decoder_top.sv
